// File: rtl/tcbe_pkg.sv
// Shared types, constants and helpers for the TEA cipher-feedback encryptor.
package tcbe_pkg;

  // TEA round constant and round count
  localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;
  localparam int          TEA_ROUNDS = 32;
  localparam int          CNT_W      = $clog2(TEA_ROUNDS);

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // Full byte count of a block
  localparam logic [3:0] BYTES_FULL = 4'd8;

  // Source of the block loaded into the round unit
  typedef enum logic [1:0] {
    SRC_ONE,
    SRC_TWO,
    SRC_THREE,
    SRC_FB
  } src_t;

  // Destination of a finished key-derivation encryption
  typedef enum logic [1:0] {
    SAVE_NONE,
    SAVE_IV,
    SAVE_SK0,
    SAVE_SK1
  } save_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  latch_in;
    logic  start;
    src_t  src;
    logic  round;
    logic  use_session;
    save_t save;
    logic  push_iv;
    logic  push_ct;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic last_blk;
  } sts_t;

  // Mask that keeps the top n bytes of a 64-bit word
  function automatic logic [63:0] top_mask(input logic [3:0] n);
    logic [63:0] m;
    case (n)
      4'd0:    m = 64'h0000_0000_0000_0000;
      4'd1:    m = 64'hff00_0000_0000_0000;
      4'd2:    m = 64'hffff_0000_0000_0000;
      4'd3:    m = 64'hffff_ff00_0000_0000;
      4'd4:    m = 64'hffff_ffff_0000_0000;
      4'd5:    m = 64'hffff_ffff_ff00_0000;
      4'd6:    m = 64'hffff_ffff_ffff_0000;
      4'd7:    m = 64'hffff_ffff_ffff_ff00;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/tcbe_in_if.sv
// Plaintext input channel: valid/ready handshake with one block per item.
interface tcbe_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_block;
  logic [3:0]  byte_count;
  logic        last_block;

  modport source (output valid, output plain_block, output byte_count, output last_block,
                  input ready);
  modport sink   (input valid, input plain_block, input byte_count, input last_block,
                  output ready);
endinterface

// File: rtl/tcbe_out_if.sv
// Result channel: valid/ready handshake carrying the IV or a ciphertext block.
interface tcbe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_word;
  logic [3:0]  out_bytes;
  logic        is_iv_block;
  logic        end_of_message;

  modport source (output valid, output cipher_word, output out_bytes, output is_iv_block,
                  output end_of_message, input ready);
  modport sink   (input valid, input cipher_word, input out_bytes, input is_iv_block,
                  input end_of_message, output ready);
endinterface

// File: rtl/tea_cfb_block_encryptor_unit.sv
// TEA encryptor in 64-bit cipher feedback mode, one item per plaintext block.
// Every block runs through a single shared TEA round unit at one round per cycle: it is
// loaded, runs 32 rounds and goes to the output register once that is free; then the
// next item is taken. The first block of a message also derives the IV and the two
// session key words with three more encryptions on the same unit and yields two results
// (IV first, then the ciphertext). The user must write the key words through the cfg
// port only while the block is idle (not enforced here); they take effect at the next
// message start. A result may wait in the output register while the next item is taken.
module tea_cfb_block_encryptor_unit (
  input  logic        clk,
  input  logic        rst_n,
  tcbe_in_if.sink     in_ch,
  tcbe_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  tcbe_pkg::cmd_t cmd;
  tcbe_pkg::sts_t sts;

  // sequencing
  tcbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // round unit, keys and result register
  tcbe_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_plain_block     (in_ch.plain_block),
    .in_byte_count      (in_ch.byte_count),
    .in_last_block      (in_ch.last_block),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_cipher_word    (out_ch.cipher_word),
    .out_out_bytes      (out_ch.out_bytes),
    .out_is_iv_block    (out_ch.is_iv_block),
    .out_end_of_message (out_ch.end_of_message),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// File: rtl/tcbe_datapath.sv
// Datapath: key registers, session state, one TEA round unit and the output register.
module tcbe_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  logic [63:0]      in_plain_block,
  input  logic [3:0]       in_byte_count,
  input  logic             in_last_block,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_cipher_word,
  output logic [3:0]       out_out_bytes,
  output logic             out_is_iv_block,
  output logic             out_end_of_message,
  input  tcbe_pkg::cmd_t   cmd,
  output tcbe_pkg::sts_t   sts
);

  logic [63:0]  key_low_r, key_high_r;
  logic [127:0] sk_r;
  logic [63:0]  fb_r;
  logic [31:0]  a_r, b_r, sum_r;
  logic [63:0]  plain_r;
  logic [3:0]   count_r;
  logic         last_r;
  logic         out_valid_r;
  logic [63:0]  out_word_r;
  logic [3:0]   out_bytes_r;
  logic         out_iv_r;
  logic         out_eom_r;

  logic [63:0]  kw0, kw1, load_blk, enc_res, cipher;
  logic [31:0]  s_nxt, a_nxt, b_nxt;
  logic [3:0]   count_sat;

  // key words for the round: configured key while deriving, session key while encrypting a block
  assign kw0 = cmd.use_session ? sk_r[63:0]   : key_low_r;
  assign kw1 = cmd.use_session ? sk_r[127:64] : key_high_r;

  // one TEA round
  assign s_nxt = sum_r + tcbe_pkg::TEA_DELTA;
  assign a_nxt = a_r + (((b_r << 4) + kw0[31:0]) ^ (b_r + s_nxt) ^ ((b_r >> 5) + kw0[63:32]));
  assign b_nxt = b_r + (((a_nxt << 4) + kw1[31:0]) ^ (a_nxt + s_nxt)
                        ^ ((a_nxt >> 5) + kw1[63:32]));

  // block loaded at the start of an encryption
  always_comb begin
    case (cmd.src)
      tcbe_pkg::SRC_ONE:   load_blk = 64'd1;
      tcbe_pkg::SRC_TWO:   load_blk = 64'd2;
      tcbe_pkg::SRC_THREE: load_blk = 64'd3;
      default:             load_blk = fb_r;
    endcase
  end

  assign enc_res   = {b_r, a_r};
  assign cipher    = (enc_res ^ plain_r) & tcbe_pkg::top_mask(count_r);
  assign count_sat = (in_byte_count > tcbe_pkg::BYTES_FULL) ? tcbe_pkg::BYTES_FULL
                                                            : in_byte_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == tcbe_pkg::CFG_KEY_LOW) key_low_r  <= cfg_wdata;
      else                                    key_high_r <= cfg_wdata;
    end
  end

  // round unit and latched item
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r   <= load_blk[31:0];
      b_r   <= load_blk[63:32];
      sum_r <= '0;
    end else if (cmd.round) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      sum_r <= s_nxt;
    end
    if (cmd.latch_in) begin
      plain_r <= in_plain_block;
      count_r <= count_sat;
      last_r  <= in_last_block;
    end
  end

  // feedback and session key
  always_ff @(posedge clk) begin
    case (cmd.save)
      tcbe_pkg::SAVE_IV:  fb_r          <= enc_res;
      tcbe_pkg::SAVE_SK0: sk_r[63:0]    <= enc_res;
      tcbe_pkg::SAVE_SK1: sk_r[127:64]  <= enc_res;
      default: ;
    endcase
    if (cmd.push_ct) fb_r <= cipher;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_iv || cmd.push_ct) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.push_iv) begin
      out_word_r  <= enc_res;
      out_bytes_r <= tcbe_pkg::BYTES_FULL;
      out_iv_r    <= 1'b1;
      out_eom_r   <= 1'b0;
    end else if (cmd.push_ct) begin
      out_word_r  <= cipher;
      out_bytes_r <= count_r;
      out_iv_r    <= 1'b0;
      out_eom_r   <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cipher_word    = out_word_r;
  assign out_out_bytes      = out_bytes_r;
  assign out_is_iv_block    = out_iv_r;
  assign out_end_of_message = out_eom_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last_blk = last_r;

endmodule

// File: rtl/tcbe_ctrl.sv
// Controller: sequences key derivation, block encryption and result hand-off.
module tcbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output tcbe_pkg::cmd_t   cmd,
  input  tcbe_pkg::sts_t   sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_DSAVE,
    ST_ENC,
    ST_ESAVE
  } state_t;

  typedef enum logic [1:0] {
    PH_IV,
    PH_SK0,
    PH_SK1
  } phase_t;

  localparam logic [tcbe_pkg::CNT_W-1:0] CNT_LAST = tcbe_pkg::CNT_W'(tcbe_pkg::TEA_ROUNDS - 1);

  state_t                      state_r, state_nxt;
  phase_t                      phase_r, phase_nxt;
  logic [tcbe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        msg_start_r, msg_start_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    msg_start_nxt = msg_start_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.start    = 1'b1;
          cnt_nxt      = '0;
          if (msg_start_r) begin
            cmd.src   = tcbe_pkg::SRC_ONE;
            phase_nxt = PH_IV;
            state_nxt = ST_DERIVE;
          end else begin
            cmd.src   = tcbe_pkg::SRC_FB;
            state_nxt = ST_ENC;
          end
        end
      end
      ST_DERIVE: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_DSAVE;
      end
      ST_DSAVE: begin
        cnt_nxt = '0;
        case (phase_r)
          PH_IV: begin
            // IV goes out first, so wait for the output register
            if (sts.out_free) begin
              cmd.push_iv = 1'b1;
              cmd.save    = tcbe_pkg::SAVE_IV;
              cmd.start   = 1'b1;
              cmd.src     = tcbe_pkg::SRC_TWO;
              phase_nxt   = PH_SK0;
              state_nxt   = ST_DERIVE;
            end
          end
          PH_SK0: begin
            cmd.save  = tcbe_pkg::SAVE_SK0;
            cmd.start = 1'b1;
            cmd.src   = tcbe_pkg::SRC_THREE;
            phase_nxt = PH_SK1;
            state_nxt = ST_DERIVE;
          end
          default: begin
            cmd.save      = tcbe_pkg::SAVE_SK1;
            cmd.start     = 1'b1;
            cmd.src       = tcbe_pkg::SRC_FB;
            msg_start_nxt = 1'b0;
            state_nxt     = ST_ENC;
          end
        endcase
      end
      ST_ENC: begin
        cmd.round       = 1'b1;
        cmd.use_session = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_ESAVE;
      end
      ST_ESAVE: begin
        if (sts.out_free) begin
          cmd.push_ct   = 1'b1;
          msg_start_nxt = sts.last_blk;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IV;
      cnt_r       <= '0;
      msg_start_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      msg_start_r <= msg_start_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // results are only pushed into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_iv || cmd.push_ct) |-> sts.out_free)
    else $error("result pushed into an occupied output register");

  // a finished message re-arms key derivation, otherwise it stays off
  a_msg_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_ct |=> (msg_start_r == $past(sts.last_blk)))
    else $error("message start flag not updated from last block");

  // the round unit is never loaded and stepped in the same cycle
  a_start_round: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && cmd.round))
    else $error("round unit loaded and stepped together");

  // an accepted item always starts the round unit
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (cmd.start && cmd.latch_in))
    else $error("accepted item did not start an encryption");

endmodule
